// File: hw/rtl/cdq_pkg.sv
// Shared types and codes for the circular deque with delete by value.
package cdq_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int KIND_WIDTH  = 3;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_BACK  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_BACK   = 3'd3,
      KIND_DELETE     = 3'd4
   } cdq_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } cdq_status_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      cdq_status_type         status;
   } cdq_result_type;

endpackage

// File: hw/rtl/cdq_ram.sv
// Entry store: one write port and one read port with registered read data.
module cdq_ram #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/cdq_seq.sv
// Sequencer that runs each request over the entry store, one request at a time.
module cdq_seq #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [cdq_pkg::KIND_WIDTH-1:0]      kind,
   input  logic signed [cdq_pkg::VALUE_WIDTH-1:0] value,
   output logic                                idle,
   output logic                                res_valid,
   input  logic                                res_take,
   output cdq_pkg::cdq_result_type             res,
   output logic                                wr_en,
   output logic [AW-1:0]                       wr_addr,
   output logic [DATA_WIDTH-1:0]               wr_data,
   output logic                                rd_en,
   output logic [AW-1:0]                       rd_addr,
   input  logic [DATA_WIDTH-1:0]               rd_data
);

   import cdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]    SUM_DEPTH = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0]  CNT_FULL  = CW'(DEPTH);
   localparam logic [AW-1:0]  LAST_SLOT = AW'(DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_POP_WAIT,
      S_CHK,
      S_SHIFT,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_HEAD,
      PH_TAIL,
      PH_MID
   } phase_type;

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   cdq_kind_type          kind_ff, kind_in;
   logic [DATA_WIDTH-1:0] value_ff, value_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [VALUE_WIDTH-1:0] res_value_ff, res_value_in;
   cdq_status_type        res_status_ff, res_status_in;

   logic [CW-1:0] count_m1;
   logic [AW-1:0] last_pos;
   logic [CW-1:0] pos_p2;
   logic          is_full;
   logic          is_empty;
   logic          hit;

   // Position in the queue to slot in the store, modulo the depth.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                             input logic [AW-1:0] pos);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, pos};
      if (sum >= SUM_DEPTH) begin
         sum = sum - SUM_DEPTH;
      end
      return sum[AW-1:0];
   endfunction

   assign count_m1 = count_ff - CW'(1);
   assign last_pos = count_m1[AW-1:0];
   assign pos_p2   = CW'(pos_ff) + CW'(2);
   assign is_full  = (count_ff == CNT_FULL);
   assign is_empty = (count_ff == '0);
   assign hit      = (rd_data == value_ff);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      value_in      = value_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = value_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               kind_in       = cdq_kind_type'(kind);
               value_in      = DATA_WIDTH'($unsigned(value));
               res_value_in  = '0;
               res_status_in = ST_OK;
               state_in      = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (kind_ff)
               KIND_PUSH_FRONT: begin
                  if (is_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     head_in  = (head_ff == '0) ? LAST_SLOT : head_ff - AW'(1);
                     wr_en    = 1'b1;
                     wr_addr  = head_in;
                     count_in = count_ff + CW'(1);
                  end
               end
               KIND_PUSH_BACK: begin
                  if (is_full) begin
                     res_status_in = ST_FULL;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = slot_of(head_ff, count_ff[AW-1:0]);
                     count_in = count_ff + CW'(1);
                  end
               end
               KIND_POP_FRONT: begin
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = S_POP_WAIT;
                  end
               end
               KIND_POP_BACK: begin
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_of(head_ff, last_pos);
                     state_in = S_POP_WAIT;
                  end
               end
               KIND_DELETE: begin
                  if (is_empty) begin
                     res_status_in = ST_EMPTY;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     phase_in = PH_HEAD;
                     state_in = S_CHK;
                  end
               end
               default: begin
                  res_status_in = ST_OK;
               end
            endcase
         end
         S_POP_WAIT: begin
            res_value_in = VALUE_WIDTH'(rd_data);
            count_in     = count_m1;
            if (kind_ff == KIND_POP_FRONT) begin
               head_in = slot_of(head_ff, AW'(1));
            end
            state_in = S_DONE;
         end
         S_CHK: begin
            // Compare order: head, then tail, then the entries in between.
            case (phase_ff)
               PH_HEAD: begin
                  if (hit) begin
                     head_in  = slot_of(head_ff, AW'(1));
                     count_in = count_m1;
                     state_in = S_DONE;
                  end else if (count_ff > CW'(1)) begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_of(head_ff, last_pos);
                     phase_in = PH_TAIL;
                  end else begin
                     res_status_in = ST_NOTFOUND;
                     state_in      = S_DONE;
                  end
               end
               PH_TAIL: begin
                  if (hit) begin
                     count_in = count_m1;
                     state_in = S_DONE;
                  end else if (count_ff > CW'(2)) begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_of(head_ff, AW'(1));
                     pos_in   = AW'(1);
                     phase_in = PH_MID;
                  end else begin
                     res_status_in = ST_NOTFOUND;
                     state_in      = S_DONE;
                  end
               end
               default: begin
                  // A match here starts the shift with the entry just after it.
                  if (hit) begin
                     rd_en    = 1'b1;
                     rd_addr  = slot_of(head_ff, pos_ff + AW'(1));
                     state_in = S_SHIFT;
                  end else if (pos_p2 < count_ff) begin
                     rd_en   = 1'b1;
                     rd_addr = slot_of(head_ff, pos_ff + AW'(1));
                     pos_in  = pos_ff + AW'(1);
                  end else begin
                     res_status_in = ST_NOTFOUND;
                     state_in      = S_DONE;
                  end
               end
            endcase
         end
         S_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = slot_of(head_ff, pos_ff);
            wr_data = rd_data;
            if (pos_p2 < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = slot_of(head_ff, pos_ff + AW'(2));
               pos_in  = pos_ff + AW'(1);
            end else begin
               count_in = count_m1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
         phase_ff      <= phase_in;
         kind_ff       <= kind_in;
         value_ff      <= value_in;
         pos_ff        <= pos_in;
         res_value_ff  <= res_value_in;
         res_status_ff <= res_status_in;
      end
   end

   assign idle       = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_DONE);
   assign res.value  = res_value_ff;
   assign res.status = res_status_ff;

endmodule

// File: hw/rtl/circular_deque_remove_by_value.sv
// rsp_valid rises once the sequencer's result is taken into the output register: a push runs
// S_EXEC, a pop adds S_POP_WAIT, a delete checks head, tail, then scans or moves interior entries.
// The sequencer takes one request at a time and a new one only once it is idle again, set by the
// single read and single write port of the entry store walked by the sequencer.
// A result waiting in the output register does not hold off the next request.
// Reset (synchronous, active high) empties the queue; stored entries are not cleared.
module circular_deque_remove_by_value #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [cdq_pkg::KIND_WIDTH-1:0]         req_type,
   input  logic signed [cdq_pkg::VALUE_WIDTH-1:0] req_item_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [cdq_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   output logic [1:0]                             rsp_status
);

   import cdq_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                  seq_idle;
   logic                  seq_res_valid;
   logic                  seq_res_take;
   cdq_result_type        seq_res;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]             rsp_status_ff, rsp_status_in;

   assign req_ready = seq_idle;

   // The output register takes a result when empty or being emptied this cycle.
   assign seq_res_take = seq_res_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (seq_res_take) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = seq_res.value;
         rsp_status_in = seq_res.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   cdq_seq #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (req_valid && req_ready),
      .kind      (req_type),
      .value     (req_item_value),
      .idle      (seq_idle),
      .res_valid (seq_res_valid),
      .res_take  (seq_res_take),
      .res       (seq_res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   cdq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

// File: sim/circular_deque_remove_by_value_test.sv
// Self-checking testbench for the circular deque with delete by value.
`timescale 1ns / 100ps

module circular_deque_remove_by_value_test;
   import cdq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int DATA_WIDTH  = 32;
   localparam int DRAIN_WAIT  = 2 * DEPTH + 16;
   localparam int IDLE_LIMIT  = 4000;
   localparam int RANDOM_REQS = 2000;

   typedef struct {
      logic [KIND_WIDTH-1:0]  kind;
      logic [VALUE_WIDTH-1:0] value;
      bit                     hold;
   } deque_request_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [KIND_WIDTH-1:0]         req_type = '0;
   logic signed [VALUE_WIDTH-1:0] req_item_value = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_out_value;
   logic [1:0]                    rsp_status;

   deque_request_type pending_requests[$];
   cdq_result_type    expected_results[$];

   // Shadow copy of the deque, advanced once per accepted request.
   logic [VALUE_WIDTH-1:0] shadow_store[DEPTH];
   int                     shadow_head = 0;
   int                     shadow_count = 0;

   int  mismatches = 0;
   int  requests_taken = 0;
   int  total_requests = 0;
   int  idle_cycles = 0;
   bit  req_hs = 1'b0;
   int  burst_left = 1;
   int  gap_left = 0;
   int  stall_mode = 0;
   int  stall_phase = 0;
   logic [15:0] stall_pattern = 16'hffff;

   circular_deque_remove_by_value #(
      .DEPTH(DEPTH),
      .DATA_WIDTH(DATA_WIDTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_item_value(req_item_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_value(rsp_out_value),
      .rsp_status(rsp_status)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int slot_at(int pos);
      return (shadow_head + pos) % DEPTH;
   endfunction

   function automatic cdq_result_type apply_request(logic [KIND_WIDTH-1:0] kind,
                                                    logic [VALUE_WIDTH-1:0] v);
      cdq_result_type r;
      bit hit;
      r.value  = '0;
      r.status = ST_OK;
      case (kind)
         KIND_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
               shadow_store[shadow_head] = v;
               shadow_count++;
            end
         end
         KIND_PUSH_BACK: begin
            if (shadow_count >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_store[slot_at(shadow_count)] = v;
               shadow_count++;
            end
         end
         KIND_POP_FRONT: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value = shadow_store[slot_at(0)];
               shadow_head = slot_at(1);
               shadow_count--;
            end
         end
         KIND_POP_BACK: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.value = shadow_store[slot_at(shadow_count - 1)];
               shadow_count--;
            end
         end
         KIND_DELETE: begin
            if (shadow_count == 0) begin
               r.status = ST_EMPTY;
            end else if (shadow_store[slot_at(0)] == v) begin
               shadow_head = slot_at(1);
               shadow_count--;
            end else if (shadow_store[slot_at(shadow_count - 1)] == v) begin
               shadow_count--;
            end else begin
               // Scan the interior from the head's successor; close the gap on a hit.
               hit = 1'b0;
               for (int p = 1; p + 1 < shadow_count && !hit; p++) begin
                  if (shadow_store[slot_at(p)] == v) begin
                     for (int q = p; q + 1 < shadow_count; q++)
                        shadow_store[slot_at(q)] = shadow_store[slot_at(q + 1)];
                     shadow_count--;
                     hit = 1'b1;
                  end
               end
               if (!hit) r.status = ST_NOTFOUND;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_request(logic [KIND_WIDTH-1:0] kind, logic [VALUE_WIDTH-1:0] v,
                              bit hold = 1'b0);
      deque_request_type item;
      item.kind  = kind;
      item.value = v;
      item.hold  = hold;
      pending_requests.push_back(item);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !req_hs)) begin
         if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (pending_requests.size() > 0 &&
                      (!pending_requests[0].hold || expected_results.size() == 0)) begin
            req_valid      <= 1'b1;
            req_type       <= pending_requests[0].kind;
            req_item_value <= pending_requests[0].value;
            void'(pending_requests.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: gap_left <= 0;
                  4, 5, 6, 7: gap_left <= $urandom_range(1, 4);
                  default:    gap_left <= $urandom_range(5, 30);
               endcase
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response receiver: stall behaviour switches to a new random mode whenever stall_phase wraps.
   always @(negedge clock) begin : rsp_side
      logic ready_next;
      case (stall_mode)
         0:       ready_next = 1'b1;
         1:       ready_next = ($urandom_range(0, 1) == 1);
         2:       ready_next = ($urandom_range(0, 3) == 0);
         default: ready_next = stall_pattern[stall_phase[3:0]];
      endcase
      rsp_ready <= ready_next;
      if (stall_phase >= 99) begin
         stall_phase   <= 0;
         stall_mode    <= $urandom_range(0, 3);
         stall_pattern <= 16'($urandom);
      end else begin
         stall_phase <= stall_phase + 1;
      end
   end

   // Monitor: check responses first, then record the expectation of a new request.
   always @(posedge clock) begin : monitor
      cdq_result_type want;
      if (reset) begin
         req_hs <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no request outstanding: out_value %h status %0d",
                      rsp_out_value, rsp_status);
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_out_value !== want.value) begin
                  $error("out_value: expected %h, actual %h", want.value, rsp_out_value);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_request(req_type, req_item_value));
            requests_taken++;
         end
         req_hs <= req_valid && req_ready;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : stimulus
      logic [VALUE_WIDTH-1:0] pool[4];
      int mode, len, r, made;
      logic [KIND_WIDTH-1:0] kind;
      logic [VALUE_WIDTH-1:0] v;

      // Directed part: empty cases, extremes, each delete path, unknown codes.
      add_request(KIND_POP_FRONT, '0);
      add_request(KIND_POP_BACK, '0);
      add_request(KIND_DELETE, 32'd5);
      add_request(KIND_PUSH_BACK, 32'h8000_0000);
      add_request(KIND_PUSH_FRONT, 32'h7fff_ffff);
      add_request(KIND_PUSH_BACK, 32'h0000_0000);
      add_request(KIND_PUSH_BACK, 32'hffff_ffff);
      add_request(KIND_PUSH_FRONT, 32'h0000_0001);
      add_request(KIND_DELETE, 32'h0000_0001);
      add_request(KIND_DELETE, 32'hffff_ffff);
      add_request(KIND_PUSH_BACK, 32'h7fff_ffff);
      add_request(KIND_DELETE, 32'h8000_0000);
      add_request(KIND_DELETE, 32'h0001_2345);
      add_request(3'd5, 32'hffff_ffff);
      add_request(3'd6, 32'h8000_0000);
      add_request(3'd7, 32'h7fff_ffff);
      add_request(KIND_POP_FRONT, '0);
      add_request(KIND_POP_BACK, 32'hffff_ffff);
      add_request(KIND_POP_BACK, '0);
      add_request(KIND_POP_BACK, '0);
      add_request(KIND_DELETE, 32'hffff_ffff);

      // Random part: phases that fill, drain, delete or send noise.
      made = 0;
      while (made < RANDOM_REQS) begin
         mode = $urandom_range(0, 3);
         len  = $urandom_range(10, 60);
         for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
               0:       pool[i] = $urandom;
               1:       pool[i] = 32'h8000_0000;
               2:       pool[i] = 32'h7fff_ffff;
               default: pool[i] = $urandom_range(0, 7);
            endcase
         end
         for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            case (mode)
               0: kind = (r < 70) ? KIND_WIDTH'(KIND_PUSH_FRONT + $urandom_range(0, 1)) :
                         (r < 85) ? KIND_DELETE :
                                    KIND_WIDTH'(KIND_POP_FRONT + $urandom_range(0, 1));
               1: kind = (r < 60) ? KIND_WIDTH'(KIND_POP_FRONT + $urandom_range(0, 1)) :
                         (r < 80) ? KIND_DELETE :
                                    KIND_WIDTH'(KIND_PUSH_FRONT + $urandom_range(0, 1));
               2: kind = (r < 50) ? KIND_DELETE :
                         (r < 80) ? KIND_WIDTH'(KIND_PUSH_FRONT + $urandom_range(0, 1)) :
                                    KIND_WIDTH'(KIND_POP_FRONT + $urandom_range(0, 1));
               default: kind = KIND_WIDTH'($urandom_range(0, 7));
            endcase
            v = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 3)] : $urandom;
            // Now and then the sender waits for every response to come back.
            add_request(kind, v, (made % 400) == 0);
            made++;
         end
      end
      total_requests = pending_requests.size();

      repeat (12) @(negedge clock);
      reset = 1'b0;

      while (!(requests_taken == total_requests && expected_results.size() == 0))
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: circular_deque_remove_by_value.f
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_ram.sv
hw/rtl/cdq_seq.sv
hw/rtl/circular_deque_remove_by_value.sv
sim/circular_deque_remove_by_value_test.sv
